// File: rtl/mie_pkg.sv
`timescale 1ns / 1ps

package mie_pkg;

  // Field widths of the input and result items.
  localparam int TAG_W       = 4;
  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 8;
  localparam int SHORT_LIMIT = 4;
  localparam int IDX_W       = 3;

  // Default number of classified items buffered between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Emission phase of the back end.
  typedef enum logic [2:0] {
    ST_HEADER = 3'b001,
    ST_MASK   = 3'b010,
    ST_DATA   = 3'b100
  } step_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [VALUE_W-1:0]   value;
    logic [MAX_BYTES-1:0] mask;
    logic                 is_long;
  } entry_t;

  // Queue control driven by the back end.
  typedef struct packed {
    logic head_valid;
    logic pop;
  } q_ctrl_t;

  // Back end status seen by the top level.
  typedef struct packed {
    logic  active;
    step_t step;
  } back_stat_t;

endpackage

// File: rtl/mie_in_if.sv
`timescale 1ns / 1ps

interface mie_in_if;
  logic                          valid;
  logic                          ready;
  logic [mie_pkg::TAG_W-1:0]     type_tag;
  logic [mie_pkg::VALUE_W-1:0]   value;
  logic [mie_pkg::COUNT_W-1:0]   byte_count;

  modport source (output valid, type_tag, value, byte_count, input ready);
  modport sink (input valid, type_tag, value, byte_count, output ready);
endinterface

// File: rtl/mie_out_if.sv
`timescale 1ns / 1ps

interface mie_out_if;
  logic                         valid;
  logic                         ready;
  logic [mie_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// File: rtl/mie_front.sv
`timescale 1ns / 1ps

module mie_front (
  mie_in_if.sink              in,
  input  logic                q_full,
  output logic                push,
  output mie_pkg::entry_t     entry
);

  logic [mie_pkg::COUNT_W-1:0] count_sat;

  // Counts above eight behave like eight.
  assign count_sat = (in.byte_count > mie_pkg::COUNT_W'(mie_pkg::MAX_BYTES)) ?
                     mie_pkg::COUNT_W'(mie_pkg::MAX_BYTES) : in.byte_count;

  always_comb begin
    entry.tag     = in.type_tag;
    entry.value   = in.value;
    entry.is_long = count_sat > mie_pkg::COUNT_W'(mie_pkg::SHORT_LIMIT);
    for (int i = 0; i < mie_pkg::MAX_BYTES; i++) begin
      entry.mask[i] = (mie_pkg::COUNT_W'(i) < count_sat) &&
                      (in.value[i*mie_pkg::BYTE_W +: mie_pkg::BYTE_W] != '0);
    end
  end

  assign in.ready = !q_full;
  assign push     = in.valid && !q_full;

endmodule

// File: rtl/mie_queue.sv
`timescale 1ns / 1ps

module mie_queue #(
  parameter int DEPTH = mie_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mie_pkg::entry_t   wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mie_pkg::entry_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mie_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/mie_back.sv
`timescale 1ns / 1ps

module mie_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  mie_pkg::entry_t      head,
  output mie_pkg::q_ctrl_t     q_ctrl,
  output mie_pkg::back_stat_t  stat,
  mie_out_if.source            out
);

  // Item under work.
  logic                            active;
  mie_pkg::step_t                  step;
  logic [mie_pkg::TAG_W-1:0]       tag;
  logic [mie_pkg::VALUE_W-1:0]     value;
  logic [mie_pkg::MAX_BYTES-1:0]   mask_rem;
  logic                            is_long;

  // Output register.
  logic                            out_valid;
  logic [mie_pkg::BYTE_W-1:0]      out_byte;
  logic                            out_last;

  // Current view: a loaded item or the queue head about to be loaded.
  mie_pkg::step_t                  cur_step;
  logic [mie_pkg::TAG_W-1:0]       cur_tag;
  logic [mie_pkg::VALUE_W-1:0]     cur_value;
  logic [mie_pkg::MAX_BYTES-1:0]   cur_mask;
  logic                            cur_long;

  logic                            advance;
  logic                            emit;
  logic [mie_pkg::IDX_W-1:0]       idx;
  logic [mie_pkg::BYTE_W-1:0]      byte_next;
  logic                            last_next;
  mie_pkg::step_t                  step_next;
  logic [mie_pkg::MAX_BYTES-1:0]   mask_next;

  assign cur_step  = active ? step : mie_pkg::ST_HEADER;
  assign cur_tag   = active ? tag : head.tag;
  assign cur_value = active ? value : head.value;
  assign cur_mask  = active ? mask_rem : head.mask;
  assign cur_long  = active ? is_long : head.is_long;

  assign advance = !out_valid || out.ready;
  assign emit    = advance && (active || head_valid);

  // Lowest nonzero byte still to be sent.
  always_comb begin
    idx = '0;
    for (int i = mie_pkg::MAX_BYTES - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        idx = mie_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    byte_next = '0;
    last_next = 1'b1;
    step_next = mie_pkg::ST_HEADER;
    mask_next = cur_mask;
    case (cur_step)
      mie_pkg::ST_HEADER: begin
        if (cur_long) begin
          byte_next = {cur_tag, 4'h0};
          last_next = 1'b0;
          step_next = mie_pkg::ST_MASK;
        end else begin
          byte_next = {cur_tag, cur_mask[mie_pkg::SHORT_LIMIT-1:0]};
          last_next = (cur_mask == '0);
          step_next = mie_pkg::ST_DATA;
        end
      end
      mie_pkg::ST_MASK: begin
        byte_next = cur_mask;
        last_next = (cur_mask == '0);
        step_next = mie_pkg::ST_DATA;
      end
      mie_pkg::ST_DATA: begin
        byte_next = cur_value[{idx, 3'b000} +: mie_pkg::BYTE_W];
        mask_next = cur_mask & (cur_mask - mie_pkg::MAX_BYTES'(1));
        last_next = (mask_next == '0);
        step_next = mie_pkg::ST_DATA;
      end
      default: begin
        byte_next = '0;
        last_next = 1'b1;
        step_next = mie_pkg::ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      step      <= mie_pkg::ST_HEADER;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= emit;
      end
      if (emit) begin
        active <= !last_next;
        step   <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_next;
      out_last <= last_next;
      mask_rem <= mask_next;
      if (!active) begin
        tag     <= head.tag;
        value   <= head.value;
        is_long <= head.is_long;
      end
    end
  end

  assign q_ctrl.head_valid = head_valid;
  assign q_ctrl.pop        = emit && !active;

  assign stat.active = active;
  assign stat.step   = step;

  assign out.valid    = out_valid;
  assign out.out_byte = out_byte;
  assign out.last     = out_last;

endmodule

// File: rtl/masked_integer_encoder_unit.sv
`timescale 1ns / 1ps

// Masked integer encoder.
// The in channel carries one transaction per integer: a 4-bit type tag, a
// 64-bit value and a byte count. The out channel carries the encoding one
// byte per transaction, with last set on the final byte of each integer.
// The encoding is a header byte (tag and, for counts up to four, the mask
// of nonzero bytes), a separate mask byte for counts above four, and then
// every nonzero byte of the examined range in ascending order.
// An integer takes 1 to 10 output bytes: one for the header, one for a
// separate mask byte, and one per nonzero data byte. The back end sends one
// byte per cycle, so the output channel sets the sustained rate.
// With an idle block, an accepted input transaction is written into the
// queue and its first byte then into the output register, from which out
// takes it; the next integer starts right after the last byte of the
// previous one, with no gap, if it is already in the queue.
// A small queue holds classified integers, so in keeps accepting while the
// receiver stalls until the queue fills; then in.ready drops.
// Synchronous reset empties the queue and the output register.
module masked_integer_encoder_unit #(
  parameter int QUEUE_DEPTH = mie_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  mie_in_if.sink    in,
  mie_out_if.source out
);

  logic                  q_full;
  logic                  push;
  mie_pkg::entry_t       wr_entry;
  logic                  head_valid;
  mie_pkg::entry_t       head;
  mie_pkg::q_ctrl_t      q_ctrl;
  mie_pkg::back_stat_t   stat;

  // The front end checks which bytes are nonzero and queues the result.
  mie_front u_front (
    .in     (in),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  mie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .full       (q_full),
    .pop        (q_ctrl.pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end walks the header, mask and data bytes of each entry.
  mie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .q_ctrl     (q_ctrl),
    .stat       (stat),
    .out        (out)
  );

  // An entry is only taken from the queue when one is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.pop |-> q_ctrl.head_valid)
    else $error("queue popped while empty");

  // An accepted transaction is visible to the back end on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> q_ctrl.head_valid)
    else $error("accepted transaction missing from queue");

  // The mask byte phase is only ever entered right after a header byte,
  // which is sent while the back end is idle, or it was already there.
  a_mask_after_header: assert property (@(posedge clk) disable iff (rst)
    (stat.active && stat.step == mie_pkg::ST_MASK && !$past(rst)) |->
    (!$past(stat.active) || $past(stat.step) == mie_pkg::ST_MASK))
    else $error("mask phase entered out of order");

endmodule
